// File: design/vlu_pkg.sv
// ----------------------------------------------------------------------------
// vlu_pkg
// Shared widths, mode codes and pipeline side-band types for the vector
// length unit.
// ----------------------------------------------------------------------------
`default_nettype none

package vlu_pkg;

  localparam int FRAC_BITS = 16;

  localparam int COMP_W = 31;
  localparam int MAG_W  = 32;
  localparam int SUM_W  = 2 * MAG_W;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int UNIT_W = 18;
  localparam int QUO_W  = FRAC_BITS + 1;
  localparam int CMP_W  = (QUO_W > UNIT_W) ? QUO_W : UNIT_W;
  localparam int PIPE_D = 3 + ROOT_W + QUO_W + 1;

  localparam logic [UNIT_W-1:0] UNIT_MAX = 18'h1FFFF;

  localparam logic [1:0] MODE_NORM = 2'd0;
  localparam logic [1:0] MODE_LEN  = 2'd1;
  localparam logic [1:0] MODE_DIST = 2'd2;

  typedef struct packed {
    logic [1:0]            mode;
    logic [2:0]            sgn;
    logic [2:0][MAG_W-1:0] mag;
  } vec_side_t;

  typedef struct packed {
    logic [1:0]            mode;
    logic [2:0]            sgn;
    logic [ROOT_W-1:0]     len;
    logic [2:0][QUO_W-1:0] quo;
  } nrm_res_t;

endpackage

`default_nettype wire

// File: design/vlu_vec_if.sv
// ----------------------------------------------------------------------------
// vlu_vec_if
// Input channel: mode and the two vectors, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface vlu_vec_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic signed [vlu_pkg::COMP_W-1:0] ax;
  logic signed [vlu_pkg::COMP_W-1:0] ay;
  logic signed [vlu_pkg::COMP_W-1:0] az;
  logic signed [vlu_pkg::COMP_W-1:0] bx;
  logic signed [vlu_pkg::COMP_W-1:0] by;
  logic signed [vlu_pkg::COMP_W-1:0] bz;

  modport source (output valid, mode, ax, ay, az, bx, by, bz, input ready);
  modport sink   (input valid, mode, ax, ay, az, bx, by, bz, output ready);
endinterface

`default_nettype wire

// File: design/vlu_res_if.sv
// ----------------------------------------------------------------------------
// vlu_res_if
// Result channel: unit vector, length and zero-length flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface vlu_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [vlu_pkg::UNIT_W-1:0] unit_x;
  logic signed [vlu_pkg::UNIT_W-1:0] unit_y;
  logic signed [vlu_pkg::UNIT_W-1:0] unit_z;
  logic [vlu_pkg::MAG_W-1:0]         length;
  logic                              zero_error;

  modport source (output valid, unit_x, unit_y, unit_z, length, zero_error, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, length, zero_error, output ready);
endinterface

`default_nettype wire

// File: design/vlu_sqrt.sv
// ----------------------------------------------------------------------------
// vlu_sqrt
// Pipelined floored integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module vlu_sqrt (
  input  wire logic                         clk,
  input  wire logic                         en,
  input  wire logic [vlu_pkg::SUM_W-1:0]    radicand,
  input  wire vlu_pkg::vec_side_t           side_in,
  output      logic [vlu_pkg::ROOT_W-1:0]   root,
  output      vlu_pkg::vec_side_t           side_out
);

  logic [vlu_pkg::REM_W-1:0]  rem  [vlu_pkg::ROOT_W+1];
  logic [vlu_pkg::ROOT_W-1:0] rt   [vlu_pkg::ROOT_W+1];
  logic [vlu_pkg::SUM_W-1:0]  rad  [vlu_pkg::ROOT_W+1];
  vlu_pkg::vec_side_t         side [vlu_pkg::ROOT_W+1];

  assign rem[0]  = '0;
  assign rt[0]   = '0;
  assign rad[0]  = radicand;
  assign side[0] = side_in;

  for (genvar k = 0; k < vlu_pkg::ROOT_W; k++) begin : g_stage
    logic [vlu_pkg::REM_W-1:0] rem_sh;
    logic [vlu_pkg::REM_W-1:0] trial;
    logic                      take;

    always_comb begin
      // bring down the next two radicand bits
      rem_sh = {rem[k][vlu_pkg::REM_W-3:0], rad[k][vlu_pkg::SUM_W-1 -: 2]};
      trial  = {1'b0, rt[k], 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? (rem_sh - trial) : rem_sh;
        rt[k+1]   <= {rt[k][vlu_pkg::ROOT_W-2:0], take};
        rad[k+1]  <= {rad[k][vlu_pkg::SUM_W-3:0], 2'b00};
        side[k+1] <= side[k];
      end
    end
  end

  assign root     = rt[vlu_pkg::ROOT_W];
  assign side_out = side[vlu_pkg::ROOT_W];

endmodule

`default_nettype wire

// File: design/vlu_norm.sv
// ----------------------------------------------------------------------------
// vlu_norm
// Three pipelined restoring dividers: (mag << FRAC_BITS) / len, one quotient
// bit per stage. Magnitudes never exceed len, so the first step needs no shift.
// ----------------------------------------------------------------------------
`default_nettype none

module vlu_norm (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [vlu_pkg::ROOT_W-1:0] len,
  input  wire vlu_pkg::vec_side_t         side_in,
  output      vlu_pkg::nrm_res_t          res
);

  localparam int R_W = vlu_pkg::ROOT_W + 1;

  logic [2:0][R_W-1:0]            rem  [vlu_pkg::QUO_W+1];
  logic [2:0][vlu_pkg::QUO_W-1:0] quo  [vlu_pkg::QUO_W+1];
  logic [vlu_pkg::ROOT_W-1:0]     dvs  [vlu_pkg::QUO_W+1];
  logic [1:0]                     mode [vlu_pkg::QUO_W+1];
  logic [2:0]                     sgn  [vlu_pkg::QUO_W+1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rem[0][c] = {1'b0, side_in.mag[c]};
      quo[0][c] = '0;
    end
  end
  assign dvs[0]  = len;
  assign mode[0] = side_in.mode;
  assign sgn[0]  = side_in.sgn;

  for (genvar j = 0; j < vlu_pkg::QUO_W; j++) begin : g_stage
    logic [2:0][R_W-1:0] r_sh;
    logic [2:0]          take;

    always_comb begin
      for (int c = 0; c < 3; c++) begin
        r_sh[c] = (j == 0) ? rem[j][c] : {rem[j][c][R_W-2:0], 1'b0};
        take[c] = (r_sh[c] >= {1'b0, dvs[j]});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          rem[j+1][c] <= take[c] ? (r_sh[c] - {1'b0, dvs[j]}) : r_sh[c];
          quo[j+1][c] <= {quo[j][c][vlu_pkg::QUO_W-2:0], take[c]};
        end
        dvs[j+1]  <= dvs[j];
        mode[j+1] <= mode[j];
        sgn[j+1]  <= sgn[j];
      end
    end
  end

  always_comb begin
    res.mode = mode[vlu_pkg::QUO_W];
    res.sgn  = sgn[vlu_pkg::QUO_W];
    res.len  = dvs[vlu_pkg::QUO_W];
    res.quo  = quo[vlu_pkg::QUO_W];
  end

endmodule

`default_nettype wire

// File: design/vector3_length_unit.sv
// ----------------------------------------------------------------------------
// vector3_length_unit
// Normalize / length / distance unit for signed Q15.16 3-D vectors.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction is accepted every clock unless the output
// holds a result that is not taken. It passes the difference, square and sum
// stages, the square root (one root bit per stage, 32 stages), then three
// parallel dividers (one quotient bit per stage) and the output register. The whole
// pipeline holds when the result is not taken; nothing is dropped or repeated.
`default_nettype none

module vector3_length_unit (
  input  wire logic clk,
  input  wire logic rst,
  vlu_vec_if.sink   vec,
  vlu_res_if.source res
);

  logic en;
  logic [vlu_pkg::PIPE_D-1:0] vld;

  assign en        = !res.valid || res.ready;
  assign vec.ready = en;
  assign res.valid = vld[vlu_pkg::PIPE_D-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[vlu_pkg::PIPE_D-2:0], vec.valid};
    end
  end

  // stage 0: difference and magnitude
  logic signed [vlu_pkg::MAG_W-1:0] d [3];
  vlu_pkg::vec_side_t s0;

  always_comb begin
    d[0] = {vec.ax[vlu_pkg::COMP_W-1], vec.ax};
    d[1] = {vec.ay[vlu_pkg::COMP_W-1], vec.ay};
    d[2] = {vec.az[vlu_pkg::COMP_W-1], vec.az};
    if (vec.mode == vlu_pkg::MODE_DIST) begin
      d[0] = d[0] - {vec.bx[vlu_pkg::COMP_W-1], vec.bx};
      d[1] = d[1] - {vec.by[vlu_pkg::COMP_W-1], vec.by};
      d[2] = d[2] - {vec.bz[vlu_pkg::COMP_W-1], vec.bz};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0.mode <= vec.mode;
      for (int c = 0; c < 3; c++) begin
        s0.sgn[c] <= d[c][vlu_pkg::MAG_W-1];
        s0.mag[c] <= d[c][vlu_pkg::MAG_W-1] ? (~d[c] + 1'b1) : d[c];
      end
    end
  end

  // stage 1: squares
  vlu_pkg::vec_side_t s1;
  logic [2:0][vlu_pkg::SUM_W-1:0] sq;

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s0;
      for (int c = 0; c < 3; c++) begin
        sq[c] <= {{vlu_pkg::MAG_W{1'b0}}, s0.mag[c]} * {{vlu_pkg::MAG_W{1'b0}}, s0.mag[c]};
      end
    end
  end

  // stage 2: sum of squares, at most 3 * 2^62
  vlu_pkg::vec_side_t s2;
  logic [vlu_pkg::SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (en) begin
      s2  <= s1;
      sum <= sq[0] + sq[1] + sq[2];
    end
  end

  logic [vlu_pkg::ROOT_W-1:0] root;
  vlu_pkg::vec_side_t         s_rt;

  vlu_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (sum),
    .side_in  (s2),
    .root     (root),
    .side_out (s_rt)
  );

  vlu_pkg::nrm_res_t nr;

  vlu_norm u_norm (
    .clk     (clk),
    .en      (en),
    .len     (root),
    .side_in (s_rt),
    .res     (nr)
  );

  // output stage: saturate, apply sign, mask by mode
  logic [2:0][vlu_pkg::UNIT_W-1:0] unit_next;
  logic                            is_norm;
  logic                            len_zero;

  always_comb begin
    logic [vlu_pkg::CMP_W-1:0]  qe;
    logic [vlu_pkg::UNIT_W-1:0] qs;
    is_norm  = (nr.mode == vlu_pkg::MODE_NORM);
    len_zero = (nr.len == '0);
    for (int c = 0; c < 3; c++) begin
      qe = vlu_pkg::CMP_W'(nr.quo[c]);
      qs = (qe > vlu_pkg::CMP_W'(vlu_pkg::UNIT_MAX)) ? vlu_pkg::UNIT_MAX
                                                     : qe[vlu_pkg::UNIT_W-1:0];
      if (!is_norm || len_zero) begin
        unit_next[c] = '0;
      end else begin
        unit_next[c] = nr.sgn[c] ? (~qs + 1'b1) : qs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.unit_x     <= unit_next[0];
      res.unit_y     <= unit_next[1];
      res.unit_z     <= unit_next[2];
      res.length     <= (nr.mode == vlu_pkg::MODE_NORM || nr.mode == vlu_pkg::MODE_LEN ||
                         nr.mode == vlu_pkg::MODE_DIST) ? nr.len : '0;
      res.zero_error <= is_norm && len_zero;
    end
  end

endmodule

`default_nettype wire

// File: bench/vector3_length_unit_tb.sv
// ----------------------------------------------------------------------------
// vector3_length_unit_tb
// Self-checking bench for the vector length unit: directed corner vectors in
// all modes, then bursty random streams with random result back-pressure and
// one long receiver hold-off, checked against a bit-exact software predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vector3_length_unit_tb;

  localparam int LATENCY   = vlu_pkg::PIPE_D;
  localparam int MAX_CYCLE = 400000;
  localparam int RANDOM_N  = 1250;
  localparam logic signed [30:0] CMAX = 31'sh3FFFFFFF;
  localparam logic signed [30:0] CMIN = -31'sh40000000;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [vlu_pkg::UNIT_W-1:0] ux;
    logic signed [vlu_pkg::UNIT_W-1:0] uy;
    logic signed [vlu_pkg::UNIT_W-1:0] uz;
    logic [vlu_pkg::MAG_W-1:0]         len;
    logic                              zerr;
  } vlu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_cnt = 0;
  int   err_cnt = 0;
  int   sent_cnt = 0;
  int   recv_cnt = 0;
  int   norm_cnt = 0;
  int   zero_cnt = 0;
  bit   hold_res = 1'b0;
  int   stall_pct = 30;

  vlu_result_t expected_q[$];

  vlu_vec_if vec ();
  vlu_res_if res ();

  vector3_length_unit dut (.clk(clk), .rst(rst), .vec(vec), .res(res));

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic logic [vlu_pkg::UNIT_W-1:0] unit_component(longint v,
      longint unsigned len);
    longint unsigned m = (v < 0) ? longint'(-v) : longint'(v);
    longint unsigned q = (m << vlu_pkg::FRAC_BITS) / len;
    if (q > 64'(vlu_pkg::UNIT_MAX)) q = 64'(vlu_pkg::UNIT_MAX);
    if (v < 0) q = 64'd0 - q;
    return q[vlu_pkg::UNIT_W-1:0];
  endfunction

  function automatic vlu_result_t predict_length(logic [1:0] mode,
      logic signed [30:0] ax, ay, az, bx, by, bz);
    vlu_result_t r = '0;
    longint vx = ax, vy = ay, vz = az;
    longint unsigned sum, len;
    if (mode == MODE_SPARE) return r;
    if (mode == vlu_pkg::MODE_DIST) begin
      vx -= bx; vy -= by; vz -= bz;
    end
    sum = longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz);
    len = isqrt(sum);
    r.len = len[31:0];
    if (mode == vlu_pkg::MODE_NORM) begin
      if (len == 0) begin
        r.zerr = 1'b1;
      end else begin
        r.ux = unit_component(vx, len);
        r.uy = unit_component(vy, len);
        r.uz = unit_component(vz, len);
      end
    end
    return r;
  endfunction

  // Sender: drive on the falling edge, hold until the transaction is taken.
  task automatic send_vector(logic [1:0] mode, logic signed [30:0] ax, ay, az, bx, by, bz);
    vec.valid <= 1'b1;
    vec.mode <= mode;
    vec.ax <= ax; vec.ay <= ay; vec.az <= az;
    vec.bx <= bx; vec.by <= by; vec.bz <= bz;
    expected_q.push_back(predict_length(mode, ax, ay, az, bx, by, bz));
    if (mode == vlu_pkg::MODE_NORM) norm_cnt++;
    if (mode == vlu_pkg::MODE_NORM && ax == 0 && ay == 0 && az == 0) zero_cnt++;
    @(posedge clk);
    while (!vec.ready) @(posedge clk);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic idle_sender(int n);
    vec.valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic signed [30:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return CMAX;
      1: return CMIN;
      2: return 31'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      3: return 31'sd0;
      default: return 31'($urandom);
    endcase
  endfunction

  // Receiver stall pattern and checker.
  always @(negedge clk) begin
    if (rst || hold_res) res.ready <= 1'b0;
    else res.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    vlu_result_t exp_r;
    if (!rst && res.valid && res.ready) begin
      recv_cnt++;
      if (expected_q.size() == 0) begin
        $error("result with no transaction pending");
        err_cnt++;
      end else begin
        exp_r = expected_q.pop_front();
        if (res.unit_x !== exp_r.ux) begin
          $error("unit_x exp %0d got %0d", exp_r.ux, res.unit_x); err_cnt++;
        end
        if (res.unit_y !== exp_r.uy) begin
          $error("unit_y exp %0d got %0d", exp_r.uy, res.unit_y); err_cnt++;
        end
        if (res.unit_z !== exp_r.uz) begin
          $error("unit_z exp %0d got %0d", exp_r.uz, res.unit_z); err_cnt++;
        end
        if (res.length !== exp_r.len) begin
          $error("length exp %0d got %0d", exp_r.len, res.length); err_cnt++;
        end
        if (res.zero_error !== exp_r.zerr) begin
          $error("zero_error exp %0d got %0d", exp_r.zerr, res.zero_error); err_cnt++;
        end
      end
    end
  end

  task automatic test_directed();
    send_vector(vlu_pkg::MODE_NORM, 0, 0, 0, 0, 0, 0);
    send_vector(vlu_pkg::MODE_LEN, 0, 0, 0, 0, 0, 0);
    send_vector(vlu_pkg::MODE_DIST, 0, 0, 0, 0, 0, 0);
    send_vector(vlu_pkg::MODE_NORM, CMAX, CMAX, CMAX, 0, 0, 0);
    send_vector(vlu_pkg::MODE_NORM, CMIN, CMIN, CMIN, 0, 0, 0);
    send_vector(vlu_pkg::MODE_LEN, CMIN, CMIN, CMIN, 0, 0, 0);
    send_vector(vlu_pkg::MODE_DIST, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    send_vector(vlu_pkg::MODE_DIST, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
    send_vector(vlu_pkg::MODE_NORM, 1, 0, 0, 0, 0, 0);
    send_vector(vlu_pkg::MODE_NORM, 0, -1, 0, 0, 0, 0);
    send_vector(vlu_pkg::MODE_NORM, 0, 0, CMIN, 0, 0, 0);
    send_vector(vlu_pkg::MODE_NORM, 1, 1, 1, 0, 0, 0);
    send_vector(vlu_pkg::MODE_NORM, 0, 0, 0, CMAX, CMIN, 5);
    send_vector(vlu_pkg::MODE_DIST, 7, -7, 9, 7, -7, 9);
    send_vector(vlu_pkg::MODE_LEN, 31'sh10000, 0, 0, CMAX, CMAX, CMAX);
    send_vector(MODE_SPARE, CMAX, CMIN, 3, CMIN, CMAX, -3);
    send_vector(MODE_SPARE, 0, 0, 0, 0, 0, 0);
    idle_sender(1);
  endtask

  task automatic test_random_stream(int n);
    int burst;
    int start;
    logic [1:0] m;
    logic signed [30:0] ax, ay, az;
    start = sent_cnt;
    while (sent_cnt - start < n) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        m = ($urandom_range(0, 19) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
        ax = rand_comp(); ay = rand_comp(); az = rand_comp();
        if ($urandom_range(0, 29) == 0) begin
          ax = 0; ay = 0; az = 0;
        end
        send_vector(m, ax, ay, az, rand_comp(), rand_comp(), rand_comp());
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 8));
    end
    idle_sender(1);
  endtask

  // Receiver holds off long enough to fill the pipeline and back up the input.
  task automatic test_backpressure();
    int hold_n = 3 * LATENCY;
    stall_pct = 0;
    fork
      begin
        hold_res = 1'b1;
        repeat (hold_n) @(posedge clk);
        hold_res = 1'b0;
      end
      repeat (LATENCY + 40)
        send_vector(2'($urandom_range(0, 2)), rand_comp(), rand_comp(), rand_comp(),
                    rand_comp(), rand_comp(), rand_comp());
    join
    idle_sender(1);
    stall_pct = 30;
  endtask

  initial begin
    vec.valid = 1'b0;
    vec.mode = vlu_pkg::MODE_NORM;
    vec.ax = '0; vec.ay = '0; vec.az = '0;
    vec.bx = '0; vec.by = '0; vec.bz = '0;
    res.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    stall_pct = 0;
    test_random_stream((RANDOM_N - sent_cnt) / 2);
    stall_pct = 60;
    test_random_stream(RANDOM_N - sent_cnt);
    stall_pct = 30;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d vectors (%0d normalize, %0d zero-length), checked %0d results.",
             sent_cnt, norm_cnt, zero_cnt, recv_cnt);
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
